### hw/rtl/mhpq_pkg.sv
// Shared types, codes and helpers for the max-heap priority queue.
// Used by mhpq_cell, max_heap_priority_queue, heap_checker and testbench; depends on nothing else.
package mhpq_pkg;

    localparam int HEAP_CAPACITY_DEF = 1024;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int KEY_MAX_W         = 64;
    localparam int KEY_IN_W          = 32;
    localparam int TOP_W             = 32;
    localparam int CNT_OUT_W         = 11;
    localparam int STATUS_W          = 2;
    localparam int LVL_W             = 5;
    localparam int MSB_IN_W          = 32;

    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    typedef enum logic [0:0] {
        MODE_INS  = 1'b0,
        MODE_SIFT = 1'b1
    } t_mode;

    typedef struct packed {
        logic             vld;
        t_mode            mode;
        logic [LVL_W-1:0] tgt;
    } t_tok;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    function automatic logic [LVL_W-1:0] msb_pos(input logic [MSB_IN_W-1:0] v);
        logic [LVL_W-1:0] p;
        p = '0;
        for (int i = 0; i < MSB_IN_W; i++) begin
            if (v[i]) begin
                p = LVL_W'(i);
            end
        end
        return p;
    endfunction

endpackage

### hw/rtl/mhpq_cell.sv
// One level of the heap: a key memory for that level, plus the compare and
// swap step that moves an insert or sift-down transaction to the next level.
// Depends on mhpq_pkg.
module mhpq_cell #(
    parameter int LEVEL     = 0,
    parameter bit IS_LAST   = 1'b0,
    parameter int DEPTH     = 1,
    parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF,
    parameter int POS_W     = 1,
    parameter int CNT_W     = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mhpq_pkg::t_tok       i_tok,
    input  logic [KEY_WIDTH-1:0] i_tok_key,
    input  logic [POS_W-1:0]     i_tok_pos,
    input  logic [CNT_W-1:0]     i_tok_cnt,
    output mhpq_pkg::t_tok       o_tok,
    output logic [KEY_WIDTH-1:0] o_tok_key,
    output logic [POS_W-1:0]     o_tok_pos,
    output logic [CNT_W-1:0]     o_tok_cnt,
    input  logic                 i_wb_vld,
    input  logic [KEY_WIDTH-1:0] i_wb_key,
    output logic                 o_wb_vld,
    output logic [KEY_WIDTH-1:0] o_wb_key,
    input  logic                 i_fetch,
    input  logic [POS_W-1:0]     i_fetch_pos,
    output logic [KEY_WIDTH-1:0] o_fetch_key,
    output logic                 o_done
);

    localparam int AW    = (DEPTH <= 2) ? 1 : $clog2(DEPTH);
    localparam int MEM_D = 2 ** AW;
    localparam int IW    = CNT_W + 1;
    localparam int LW    = mhpq_pkg::LVL_W;
    localparam logic [LW-1:0] MY_LVL   = LW'(LEVEL);
    localparam logic [LW-1:0] NEXT_LVL = LW'(LEVEL + 1);

    logic [KEY_WIDTH-1:0] r_mem [MEM_D];

    logic                 r_act;
    mhpq_pkg::t_mode      r_mode;
    logic [LW-1:0]        r_tgt;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] r_rd_a;
    logic [KEY_WIDTH-1:0] r_rd_b;
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     r_slot;
    logic [CNT_W-1:0]     r_cnt;

    mhpq_pkg::t_tok       r_otok;
    logic [KEY_WIDTH-1:0] r_okey;
    logic [POS_W-1:0]     r_opos;
    logic [CNT_W-1:0]     r_ocnt;
    logic                 r_owb_vld;
    logic [KEY_WIDTH-1:0] r_owb_key;
    logic                 r_done;

    mhpq_pkg::t_tok       n_tok;
    logic [KEY_WIDTH-1:0] n_okey;
    logic [POS_W-1:0]     n_opos;
    logic                 n_wb_vld;
    logic [KEY_WIDTH-1:0] n_wb_key;
    logic                 n_done;
    logic [POS_W-1:0]     n_slot;

    logic [POS_W-1:0]     in_left;
    logic [POS_W-1:0]     in_right;
    logic [AW-1:0]        rd_addr_a;
    logic                 rd_en;

    logic [POS_W-1:0]     c_left;
    logic [POS_W-1:0]     c_right;
    logic [POS_W-1:0]     ins_next;
    logic [LW-1:0]        sh;
    logic [CNT_W-1:0]     cnt_sh;
    logic                 at_tgt;
    logic                 ins_gt;
    logic [IW-1:0]        l_idx;
    logic [IW-1:0]        r_idx;
    logic                 l_ok;
    logic                 r_ok;
    logic                 pick_r;
    logic [KEY_WIDTH-1:0] best_key;
    logic [POS_W-1:0]     best_pos;
    logic                 go_down;
    logic [AW-1:0]        wb_addr;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [KEY_WIDTH-1:0] wdata;

    assign in_left  = i_tok_pos << 1;
    assign in_right = in_left | POS_W'(1);
    assign rd_en    = i_fetch | i_tok.vld;

    always_comb begin
        if (i_fetch) begin
            rd_addr_a = i_fetch_pos[AW-1:0];
        end else if (i_tok.mode == mhpq_pkg::MODE_SIFT) begin
            rd_addr_a = in_left[AW-1:0];
        end else begin
            rd_addr_a = i_tok_pos[AW-1:0];
        end
    end

    assign c_left   = r_pos << 1;
    assign c_right  = c_left | POS_W'(1);
    assign sh       = r_tgt - NEXT_LVL;
    assign cnt_sh   = r_cnt >> sh;
    assign ins_next = c_left | POS_W'(cnt_sh[0]);
    assign at_tgt   = (r_tgt == MY_LVL);
    assign ins_gt   = $signed(r_key) > $signed(r_rd_a);

    assign l_idx    = (IW'(1) << LEVEL) + (IW'(r_pos) << 1);
    assign r_idx    = l_idx + IW'(1);
    assign l_ok     = l_idx <= IW'(r_cnt);
    assign r_ok     = r_idx <= IW'(r_cnt);
    assign pick_r   = r_ok && ($signed(r_rd_b) > $signed(r_rd_a));
    assign best_key = pick_r ? r_rd_b : r_rd_a;
    assign best_pos = pick_r ? c_right : c_left;
    assign go_down  = l_ok && ($signed(best_key) > $signed(r_key));

    assign wb_addr  = (LEVEL == 0) ? '0 : r_slot[AW-1:0];

    always_comb begin
        n_tok    = '0;
        n_okey   = r_key;
        n_opos   = c_left;
        n_wb_vld = 1'b0;
        n_wb_key = r_key;
        n_done   = 1'b0;
        n_slot   = r_slot;
        we       = 1'b0;
        waddr    = wb_addr;
        wdata    = i_wb_key;
        if (i_wb_vld) begin
            we = 1'b1;
        end
        if (r_act) begin
            case (r_mode)
                mhpq_pkg::MODE_INS: begin
                    if (at_tgt) begin
                        we     = 1'b1;
                        waddr  = r_pos[AW-1:0];
                        wdata  = r_key;
                        n_done = 1'b1;
                    end else begin
                        if (ins_gt) begin
                            we    = 1'b1;
                            waddr = r_pos[AW-1:0];
                            wdata = r_key;
                        end
                        n_tok.vld  = 1'b1;
                        n_tok.mode = mhpq_pkg::MODE_INS;
                        n_tok.tgt  = r_tgt;
                        n_okey     = ins_gt ? r_rd_a : r_key;
                        n_opos     = ins_next;
                    end
                end
                mhpq_pkg::MODE_SIFT: begin
                    n_wb_vld = 1'b1;
                    n_wb_key = go_down ? best_key : r_key;
                    if (go_down) begin
                        if (IS_LAST) begin
                            we     = 1'b1;
                            waddr  = best_pos[AW-1:0];
                            wdata  = r_key;
                            n_done = 1'b1;
                        end else begin
                            n_tok.vld  = 1'b1;
                            n_tok.mode = mhpq_pkg::MODE_SIFT;
                            n_tok.tgt  = r_tgt;
                            n_okey     = r_key;
                            n_opos     = best_pos;
                            n_slot     = best_pos;
                        end
                    end else begin
                        n_done = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= 1'b0;
            r_otok    <= '0;
            r_owb_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_act     <= i_tok.vld;
            r_otok    <= n_tok;
            r_owb_vld <= n_wb_vld;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.vld) begin
            r_mode <= i_tok.mode;
            r_tgt  <= i_tok.tgt;
            r_key  <= i_tok_key;
            r_pos  <= i_tok_pos;
            r_cnt  <= i_tok_cnt;
        end
        r_slot    <= n_slot;
        r_okey    <= n_okey;
        r_opos    <= n_opos;
        r_ocnt    <= r_cnt;
        r_owb_key <= n_wb_key;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[rd_addr_a];
        end
        if (i_tok.vld) begin
            r_rd_b <= r_mem[in_right[AW-1:0]];
        end
    end

    assign o_tok       = r_otok;
    assign o_tok_key   = r_okey;
    assign o_tok_pos   = r_opos;
    assign o_tok_cnt   = r_ocnt;
    assign o_wb_vld    = r_owb_vld;
    assign o_wb_key    = r_owb_key;
    assign o_fetch_key = r_rd_a;
    assign o_done      = r_done;

endmodule

### hw/rtl/max_heap_priority_queue.sv
// Insert: the new key walks from the root down to the level of its new slot.
// Extract: the last entry is fetched and sifted down from the root, level by level.
// Each level cell reads its memory for a key, then compares and writes.
// Dropped inserts, empty extracts and removal of the last key answer in the cycle after start is taken.
// The next transaction is taken in the cycle of the result strobe; the receiver cannot stall.
// Reset clears the entry count and the control state; the level memories are not cleared.
module max_heap_priority_queue #(
    parameter int HEAP_CAPACITY = mhpq_pkg::HEAP_CAPACITY_DEF,
    parameter int KEY_WIDTH     = mhpq_pkg::KEY_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_kind,
    input  logic signed [mhpq_pkg::KEY_IN_W-1:0] i_key_in,
    output logic                                 o_valid,
    output logic signed [mhpq_pkg::TOP_W-1:0]    o_top_key,
    output logic [mhpq_pkg::STATUS_W-1:0]        o_status,
    output logic [mhpq_pkg::CNT_OUT_W-1:0]       o_entry_count
);

    localparam int CW    = $clog2(HEAP_CAPACITY + 1);
    localparam int LVLS  = CW;
    localparam int POS_W = LVLS - 1;
    localparam int LI    = $clog2(LVLS);
    localparam int LW    = mhpq_pkg::LVL_W;
    localparam int XW    = mhpq_pkg::KEY_MAX_W;
    localparam int MW    = mhpq_pkg::MSB_IN_W;
    localparam int TW    = mhpq_pkg::TOP_W;
    localparam int OW    = mhpq_pkg::CNT_OUT_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_RUN   = 3'b100
    } t_state;

    function automatic logic [TW-1:0] key_out(input logic [KEY_WIDTH-1:0] k);
        logic [XW-1:0] w;
        w = XW'(k);
        return w[TW-1:0];
    endfunction

    function automatic logic [OW-1:0] cnt_out(input logic [CW-1:0] c);
        logic [MW-1:0] w;
        w = MW'(c);
        return w[OW-1:0];
    endfunction

    t_state               r_state, n_state;
    logic [CW-1:0]        r_held, n_held;
    logic                 r_valid, n_valid;
    logic [KEY_WIDTH-1:0] r_root, n_root;
    logic [KEY_WIDTH-1:0] r_out_top, n_out_top;
    logic [LW-1:0]        r_lvl, n_lvl;
    logic [TW-1:0]        r_res_top, n_res_top;
    mhpq_pkg::t_status    r_res_st, n_res_st;
    logic [OW-1:0]        r_res_cnt, n_res_cnt;

    mhpq_pkg::t_tok       tok_in   [LVLS];
    mhpq_pkg::t_tok       tok_out  [LVLS];
    logic [KEY_WIDTH-1:0] tkey_in  [LVLS];
    logic [KEY_WIDTH-1:0] tkey_out [LVLS];
    logic [POS_W-1:0]     pos_in   [LVLS];
    logic [POS_W-1:0]     pos_out  [LVLS];
    logic [CW-1:0]        cnt_in   [LVLS];
    logic [CW-1:0]        cnt_out_c[LVLS];
    logic                 wb_vld   [LVLS];
    logic [KEY_WIDTH-1:0] wb_key   [LVLS];
    logic                 wb_in_vld[LVLS];
    logic [KEY_WIDTH-1:0] wb_in_key[LVLS];
    logic [KEY_WIDTH-1:0] fetch_key[LVLS];
    logic [LVLS-1:0]      fetch_en;
    logic [LVLS-1:0]      done_vec;

    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    logic [CW-1:0]        n_ins;
    logic [XW-1:0]        kin64;
    logic [KEY_WIDTH-1:0] key_new;
    logic [KEY_WIDTH-1:0] root_new;
    logic                 ins_go;
    logic                 fetch_go;
    logic [LW-1:0]        fetch_lvl;
    logic [CW-1:0]        fetch_full;
    logic [POS_W-1:0]     fetch_pos;
    logic [LW-1:0]        ins_tgt;
    logic [KEY_WIDTH-1:0] fetched;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && (r_state == S_IDLE);
    assign is_full  = r_held >= CW'(HEAP_CAPACITY);
    assign is_empty = (r_held == '0);
    assign n_ins    = r_held + CW'(1);
    assign kin64    = XW'($unsigned(i_key_in));
    assign key_new  = kin64[KEY_WIDTH-1:0];
    assign root_new = (is_empty || ($signed(key_new) > $signed(r_root))) ? key_new : r_root;

    assign ins_go   = accept && (i_kind == mhpq_pkg::KIND_INSERT) && !is_full;
    assign fetch_go = accept && (i_kind == mhpq_pkg::KIND_EXTRACT) && !is_empty
                      && (r_held != CW'(1));

    assign fetch_lvl  = mhpq_pkg::msb_pos(MW'(r_held));
    assign fetch_full = r_held ^ (CW'(1) << fetch_lvl);
    assign fetch_pos  = fetch_full[POS_W-1:0];
    assign ins_tgt    = mhpq_pkg::msb_pos(MW'(n_ins));
    assign fetched    = fetch_key[r_lvl[LI-1:0]];

    assign tok_in[0]  = '{vld: ins_go, mode: mhpq_pkg::MODE_INS, tgt: ins_tgt};
    assign tkey_in[0] = key_new;
    assign pos_in[0]  = '0;
    assign cnt_in[0]  = n_ins;

    always_comb begin
        if (r_state == S_FETCH) begin
            tok_in[1]  = '{vld: 1'b1, mode: mhpq_pkg::MODE_SIFT, tgt: '0};
            tkey_in[1] = fetched;
            pos_in[1]  = '0;
            cnt_in[1]  = r_held;
        end else begin
            tok_in[1]  = tok_out[0];
            tkey_in[1] = tkey_out[0];
            pos_in[1]  = pos_out[0];
            cnt_in[1]  = cnt_out_c[0];
        end
    end

    for (genvar k = 0; k < LVLS; k++) begin : g_lvl
        localparam int DEP = (k == LVLS - 1) ? HEAP_CAPACITY - (2 ** k) + 1 : 2 ** k;

        if (k >= 2) begin : g_chain
            assign tok_in[k]  = tok_out[k-1];
            assign tkey_in[k] = tkey_out[k-1];
            assign pos_in[k]  = pos_out[k-1];
            assign cnt_in[k]  = cnt_out_c[k-1];
        end

        if (k < LVLS - 1) begin : g_wb
            assign wb_in_vld[k] = wb_vld[k+1];
            assign wb_in_key[k] = wb_key[k+1];
        end else begin : g_wb_end
            assign wb_in_vld[k] = 1'b0;
            assign wb_in_key[k] = '0;
        end

        assign fetch_en[k] = fetch_go && (fetch_lvl == LW'(k));

        mhpq_cell #(
            .LEVEL     (k),
            .IS_LAST   (k == LVLS - 1),
            .DEPTH     (DEP),
            .KEY_WIDTH (KEY_WIDTH),
            .POS_W     (POS_W),
            .CNT_W     (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (tok_in[k]),
            .i_tok_key   (tkey_in[k]),
            .i_tok_pos   (pos_in[k]),
            .i_tok_cnt   (cnt_in[k]),
            .o_tok       (tok_out[k]),
            .o_tok_key   (tkey_out[k]),
            .o_tok_pos   (pos_out[k]),
            .o_tok_cnt   (cnt_out_c[k]),
            .i_wb_vld    (wb_in_vld[k]),
            .i_wb_key    (wb_in_key[k]),
            .o_wb_vld    (wb_vld[k]),
            .o_wb_key    (wb_key[k]),
            .i_fetch     (fetch_en[k]),
            .i_fetch_pos (fetch_pos),
            .o_fetch_key (fetch_key[k]),
            .o_done      (done_vec[k])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_held    = r_held;
        n_valid   = 1'b0;
        n_root    = r_root;
        n_out_top = r_out_top;
        n_lvl     = r_lvl;
        n_res_top = r_res_top;
        n_res_st  = r_res_st;
        n_res_cnt = r_res_cnt;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == mhpq_pkg::KIND_INSERT) begin
                        if (is_full) begin
                            n_valid   = 1'b1;
                            n_res_top = key_out(r_root);
                            n_res_st  = mhpq_pkg::ST_FULL;
                            n_res_cnt = cnt_out(r_held);
                        end else begin
                            n_held    = n_ins;
                            n_root    = root_new;
                            n_out_top = root_new;
                            n_state   = S_RUN;
                        end
                    end else if (is_empty) begin
                        n_valid   = 1'b1;
                        n_res_top = '1;
                        n_res_st  = mhpq_pkg::ST_EMPTY;
                        n_res_cnt = cnt_out(r_held);
                    end else if (r_held == CW'(1)) begin
                        n_valid   = 1'b1;
                        n_held    = '0;
                        n_res_top = key_out(r_root);
                        n_res_st  = mhpq_pkg::ST_OK;
                        n_res_cnt = '0;
                    end else begin
                        n_held    = r_held - CW'(1);
                        n_out_top = r_root;
                        n_lvl     = fetch_lvl;
                        n_state   = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (wb_vld[1]) begin
                    n_root = wb_key[1];
                end
                if (|done_vec) begin
                    n_valid   = 1'b1;
                    n_res_top = key_out(r_out_top);
                    n_res_st  = mhpq_pkg::ST_OK;
                    n_res_cnt = cnt_out(r_held);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root    <= n_root;
        r_out_top <= n_out_top;
        r_lvl     <= n_lvl;
        r_res_top <= n_res_top;
        r_res_st  <= n_res_st;
        r_res_cnt <= n_res_cnt;
    end

    assign o_valid       = r_valid;
    assign o_top_key     = r_res_top;
    assign o_status      = r_res_st;
    assign o_entry_count = r_res_cnt;

`ifndef SYNTHESIS
    a_root_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !wb_vld[0])
        else $error("The root cell sent a write-back toward a level that does not exist.");

    a_last_no_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tok_out[LVLS-1].vld)
        else $error("The deepest cell passed a transaction past the end of the chain.");

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|done_vec) |-> (r_state == S_RUN))
        else $error("A cell finished a transaction while the sequencer was not waiting.");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("A result strobe appeared while a transaction was still in flight.");
`endif

endmodule

### bench/heap_checker.sv
`timescale 1ns / 100ps
// Checker for the max-heap priority queue: keeps its own heap, predicts each reply and compares.
// Depends on mhpq_pkg for widths, operation codes and status codes.
module heap_checker #(
    parameter int HEAP_CAPACITY = mhpq_pkg::HEAP_CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  logic                                 i_kind,
    input  logic signed [mhpq_pkg::KEY_IN_W-1:0] i_key_in,
    input  logic                                 i_valid,
    input  logic signed [mhpq_pkg::TOP_W-1:0]    i_top_key,
    input  logic [mhpq_pkg::STATUS_W-1:0]        i_status,
    input  logic [mhpq_pkg::CNT_OUT_W-1:0]       i_entry_count,
    output int                                   o_mismatches,
    output int                                   o_outstanding
);
    import mhpq_pkg::*;

    typedef struct {
        logic signed [TOP_W-1:0] top_key;
        t_status                 status;
        logic [CNT_OUT_W-1:0]    entry_count;
    } t_heap_reply;

    logic signed [KEY_IN_W-1:0] heap_keys [HEAP_CAPACITY];
    int                         held = 0;
    t_heap_reply                replies_due [$];
    int                         mismatch_total = 0;
    int                         replies_waiting = 0;

    assign o_mismatches  = mismatch_total;
    assign o_outstanding = replies_waiting;

    function automatic t_heap_reply heap_apply(input logic kind,
                                               input logic signed [KEY_IN_W-1:0] key);
        t_heap_reply                reply;
        int                         pos;
        int                         up;
        int                         lc;
        int                         best;
        logic signed [KEY_IN_W-1:0] tmp;
        reply.status = ST_OK;
        if (kind == KIND_INSERT) begin
            if (held >= HEAP_CAPACITY) begin
                reply.status = ST_FULL;
            end else begin
                pos = held;
                heap_keys[pos] = key;
                held++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (heap_keys[pos] <= heap_keys[up]) break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[up];
                    heap_keys[up] = tmp;
                    pos = up;
                end
            end
            reply.top_key = heap_keys[0];
        end else if (held == 0) begin
            reply.status  = ST_EMPTY;
            reply.top_key = '1;
        end else begin
            reply.top_key = heap_keys[0];
            held--;
            if (held > 0) begin
                heap_keys[0] = heap_keys[held];
                pos = 0;
                forever begin
                    lc = 2 * pos + 1;
                    if (lc >= held) break;
                    best = lc;
                    // The left child wins a tie between the children.
                    if (lc + 1 < held && heap_keys[lc + 1] > heap_keys[lc]) best = lc + 1;
                    if (heap_keys[best] <= heap_keys[pos]) break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[best];
                    heap_keys[best] = tmp;
                    pos = best;
                end
            end
        end
        reply.entry_count = CNT_OUT_W'(held);
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_heap_reply want;
        if (!i_rst_n) begin
            held = 0;
            replies_due.delete();
        end else begin
            if (i_start && !i_busy) begin
                replies_due.push_back(heap_apply(i_kind, i_key_in));
            end
            if (i_valid) begin
                if (replies_due.size() == 0) begin
                    if (mismatch_total < 10) begin
                        $display("%0t: unexpected result: top_key %0d status %0d count %0d",
                                 $realtime, i_top_key, i_status, i_entry_count);
                    end
                    mismatch_total++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_top_key !== want.top_key || i_status !== want.status ||
                        i_entry_count !== want.entry_count) begin
                        if (mismatch_total < 10) begin
                            $display("%0t: mismatch, expected top_key %0d status %0d count %0d",
                                     $realtime, want.top_key, want.status, want.entry_count);
                            $display("%0t: mismatch, actual top_key %0d status %0d count %0d",
                                     $realtime, i_top_key, i_status, i_entry_count);
                        end
                        mismatch_total++;
                    end
                end
            end
        end
        replies_waiting = replies_due.size();
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Top of the max-heap priority queue bench: clock, reset, operation traffic and the verdict.
// Depends on mhpq_pkg, max_heap_priority_queue and heap_checker.
module testbench;
    import mhpq_pkg::*;

    localparam int CAPACITY     = HEAP_CAPACITY_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic signed [KEY_IN_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_IN_W-1:0] KEY_MIN = 32'sh8000_0000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic                        i_kind;
    logic signed [KEY_IN_W-1:0]  i_key_in;
    logic                        o_valid;
    logic signed [TOP_W-1:0]     o_top_key;
    logic [STATUS_W-1:0]         o_status;
    logic [CNT_OUT_W-1:0]        o_entry_count;
    int                          mismatches;
    int                          outstanding;
    int                          occupancy;
    int                          sender_idle_pct;

    max_heap_priority_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_key_in      (i_key_in),
        .o_valid       (o_valid),
        .o_top_key     (o_top_key),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    heap_checker #(
        .HEAP_CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_kind        (i_kind),
        .i_key_in      (i_key_in),
        .i_valid       (o_valid),
        .i_top_key     (o_top_key),
        .i_status      (o_status),
        .i_entry_count (o_entry_count),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic signed [KEY_IN_W-1:0] pick_key();
        case ($urandom_range(9))
            0: return KEY_MAX;
            1: return KEY_MIN;
            2: return '0;
            3: return '1;
            // A narrow range makes equal keys common.
            4, 5: return KEY_IN_W'($signed($urandom_range(0, 7)) - 4);
            default: return $urandom();
        endcase
    endfunction

    task automatic issue_op(input logic kind, input logic signed [KEY_IN_W-1:0] key);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
        end
        start    <= 1'b1;
        i_kind   <= kind;
        i_key_in <= key;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (kind == KIND_INSERT && occupancy < CAPACITY) occupancy++;
        if (kind == KIND_EXTRACT && occupancy > 0) occupancy--;
    endtask

    task automatic run_mix(input int count, input int extract_pct);
        for (int n = 0; n < count; n++) begin
            issue_op(($urandom_range(99) < extract_pct) ? KIND_EXTRACT : KIND_INSERT,
                     pick_key());
        end
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid) quiet = 0;
            else quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_kind          = KIND_INSERT;
        i_key_in        = '0;
        occupancy       = 0;
        sender_idle_pct = 30;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        issue_op(KIND_EXTRACT, KEY_MAX);
        issue_op(KIND_INSERT, KEY_MIN);
        issue_op(KIND_EXTRACT, '0);
        issue_op(KIND_INSERT, KEY_MAX);
        issue_op(KIND_INSERT, KEY_MIN);
        issue_op(KIND_INSERT, 32'sh5555_5555);
        issue_op(KIND_INSERT, 32'shAAAA_AAAA);
        issue_op(KIND_INSERT, KEY_MAX);
        issue_op(KIND_INSERT, '0);
        issue_op(KIND_INSERT, '1);
        for (int n = 0; n < 8; n++) issue_op(KIND_EXTRACT, '1);
        for (int n = 0; n < 4; n++) issue_op(KIND_INSERT, 32'sd5);
        issue_op(KIND_EXTRACT, '0);
        issue_op(KIND_EXTRACT, '0);

        run_mix(180, 25);
        sender_idle_pct = 49;
        run_mix(180, 30);
        sender_idle_pct = 0;
        run_mix(60, 35);
        while (occupancy > 0) issue_op(KIND_EXTRACT, pick_key());
        issue_op(KIND_EXTRACT, pick_key());
        issue_op(KIND_EXTRACT, pick_key());
        start <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
